// ----- rtl/mbtrr_pkg.sv -----
// Shared types and constants for the Modbus TCP register responder.
// Used by the responder top level and the testbench; depends on nothing.
package mbtrr_pkg;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_LIMIT  = 3'd3,
    ST_UNSUP  = 3'd4
  } status_t;

  localparam logic [1:0] REQ_CLIENT   = 2'd0;
  localparam logic [1:0] REQ_IN_WRITE = 2'd1;
  localparam logic [1:0] REQ_HR_WRITE = 2'd2;

  localparam logic [7:0] FC_READ_COILS = 8'd1;
  localparam logic [7:0] FC_READ_HOLD  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL = 8'd5;

  localparam logic [1:0] CFG_UNIT_ID   = 2'd0;
  localparam logic [1:0] CFG_COIL_CNT  = 2'd1;
  localparam logic [1:0] CFG_INPUT_CNT = 2'd2;
  localparam logic [1:0] CFG_HOLD_CNT  = 2'd3;

  localparam logic [3:0] HDR_LAST_READ  = 4'd8;
  localparam logic [3:0] HDR_LAST_WCOIL = 4'd10;
  localparam logic [6:0] HDR_BYTES      = 7'd9;
  localparam logic [7:0] WCOIL_LEN      = 8'd6;
  localparam logic [7:0] COIL_ON_BYTE   = 8'hFF;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_ERR, S_HDR,
    S_RREQ, S_RHI, S_RLO, S_CREQ, S_CACC, S_CEMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic        coil_on;
    logic [15:0] write_value;
  } req_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
    status_t    resp_status;
  } resp_t;

endpackage

// ----- rtl/mbtrr_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
// Payload type is a parameter; typically mbtrr_pkg::req_t or mbtrr_pkg::resp_t.
interface mbtrr_stream_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/modbus_tcp_register_responder.sv -----
// Modbus TCP register responder top level: request checks, frame sequencer,
// store access. Depends on mbtrr_pkg, mbtrr_stream_if and mbtrr_ram.
//
//   Channel  Dir  Payload              Beat meaning
//   in_s     in   mbtrr_pkg::req_t     one client request or local store write
//   out_s    out  mbtrr_pkg::resp_t    one response byte or one error item
//   cfg_*    in   index + 11-bit data  one register write per enabled cycle
//
// After reset a clearing pass zeroes all three stores, stepping through every
// address of the deepest store (1024 with default parameters); no request is
// taken meanwhile. A local write is done as its beat is accepted. A client
// request passes the check state, one state per header byte, a memory read,
// high byte and low byte state per register, a read and accumulate state per
// coil and an emit state per packed byte; each store has one read port.
// Output backpressure stalls the sequencer but not the output register.
module modbus_tcp_register_responder #(
  parameter int COIL_DEPTH         = 1024,
  parameter int INPUT_REG_DEPTH    = 256,
  parameter int HOLDING_REG_DEPTH  = 256,
  parameter int MAX_REGS_PER_READ  = 27,
  parameter int MAX_COILS_PER_READ = 440
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mbtrr_stream_if.sink          in_s,
  mbtrr_stream_if.source        out_s,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [10:0]           cfg_wdata
);
  localparam int CAW = $clog2(COIL_DEPTH);
  localparam int IAW = $clog2(INPUT_REG_DEPTH);
  localparam int HAW = $clog2(HOLDING_REG_DEPTH);
  localparam int MAXD_A = (COIL_DEPTH > INPUT_REG_DEPTH) ? COIL_DEPTH : INPUT_REG_DEPTH;
  localparam int MAXD = (MAXD_A > HOLDING_REG_DEPTH) ? MAXD_A : HOLDING_REG_DEPTH;
  localparam int CLW = $clog2(MAXD);
  localparam logic [16:0] CDEP = 17'(COIL_DEPTH);
  localparam logic [16:0] IDEP = 17'(INPUT_REG_DEPTH);
  localparam logic [16:0] HDEP = 17'(HOLDING_REG_DEPTH);

  // Configuration registers.
  logic [7:0]  unit_id_r;
  logic [10:0] coil_cnt_r;
  logic [8:0]  in_cnt_r, hold_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r  <= 8'd1;
      coil_cnt_r <= 11'd1024;
      in_cnt_r   <= 9'd256;
      hold_cnt_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mbtrr_pkg::CFG_UNIT_ID:   unit_id_r  <= cfg_wdata[7:0];
        mbtrr_pkg::CFG_COIL_CNT:  coil_cnt_r <= cfg_wdata;
        mbtrr_pkg::CFG_INPUT_CNT: in_cnt_r   <= cfg_wdata[8:0];
        mbtrr_pkg::CFG_HOLD_CNT:  hold_cnt_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Counts in use, capped at the store depths.
  logic [16:0] ncoil, nin, nhold;
  assign ncoil = (17'(coil_cnt_r) > CDEP) ? CDEP : 17'(coil_cnt_r);
  assign nin   = (17'(in_cnt_r)   > IDEP) ? IDEP : 17'(in_cnt_r);
  assign nhold = (17'(hold_cnt_r) > HDEP) ? HDEP : 17'(hold_cnt_r);

  // Sequencer state.
  mbtrr_pkg::state_t state_r, state_nxt;
  mbtrr_pkg::req_t   req_r;
  mbtrr_pkg::status_t status_r, status_nxt;
  logic [CLW-1:0] clr_r, clr_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  hdr_end_r, hdr_end_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  b8_r, b8_nxt;
  logic [8:0]  i_r, i_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  acc_r, acc_nxt;

  // Output register.
  logic        o_valid_r;
  mbtrr_pkg::resp_t o_data_r;
  logic        o_free, emit;
  mbtrr_pkg::resp_t emit_data;

  assign o_free      = !o_valid_r || out_s.ready;
  assign out_s.valid = o_valid_r;
  assign out_s.data  = o_data_r;

  logic in_acc;
  assign in_s.ready = (state_r == mbtrr_pkg::S_IDLE);
  assign in_acc     = in_s.valid && in_s.ready;

  // Store ports.
  logic           coil_we, coil_re, coil_wd, coil_rd;
  logic [CAW-1:0] coil_wa, coil_ra;
  logic           in_we, in_re, hold_we, hold_re;
  logic [IAW-1:0] in_wa, in_ra;
  logic [HAW-1:0] hold_wa, hold_ra;
  logic [15:0]    in_wd, hold_wd, in_rd, hold_rd, reg_rd;
  logic [16:0]    rd_addr;

  mbtrr_ram #(.WIDTH(1), .DEPTH(COIL_DEPTH)) u_coil (
    .clk, .we(coil_we), .waddr(coil_wa), .wdata(coil_wd),
    .re(coil_re), .raddr(coil_ra), .rdata(coil_rd)
  );
  mbtrr_ram #(.WIDTH(16), .DEPTH(INPUT_REG_DEPTH)) u_input (
    .clk, .we(in_we), .waddr(in_wa), .wdata(in_wd),
    .re(in_re), .raddr(in_ra), .rdata(in_rd)
  );
  mbtrr_ram #(.WIDTH(16), .DEPTH(HOLDING_REG_DEPTH)) u_hold (
    .clk, .we(hold_we), .waddr(hold_wa), .wdata(hold_wd),
    .re(hold_re), .raddr(hold_ra), .rdata(hold_rd)
  );

  assign rd_addr = 17'(req_r.start_address) + 17'(i_r);
  assign coil_ra = rd_addr[CAW-1:0];
  assign in_ra   = rd_addr[IAW-1:0];
  assign hold_ra = rd_addr[HAW-1:0];
  assign reg_rd  = (req_r.function_code == mbtrr_pkg::FC_READ_HOLD) ? hold_rd : in_rd;

  // Request check, evaluated in the check state from the latched request.
  logic [16:0] chk_cnt, end_addr;
  logic        is_coil, is_reg, is_wcoil, chk_range, over_limit;
  logic [9:0]  coil_bytes_w;

  assign is_coil  = (req_r.function_code == mbtrr_pkg::FC_READ_COILS);
  assign is_reg   = (req_r.function_code == mbtrr_pkg::FC_READ_HOLD) ||
                    (req_r.function_code == mbtrr_pkg::FC_READ_INPUT);
  assign is_wcoil = (req_r.function_code == mbtrr_pkg::FC_WRITE_COIL);
  assign chk_cnt  = is_coil || is_wcoil ? ncoil :
                    (req_r.function_code == mbtrr_pkg::FC_READ_HOLD) ? nhold : nin;
  assign end_addr = 17'(req_r.start_address) + 17'(req_r.quantity);
  assign chk_range = (17'(req_r.start_address) >= chk_cnt) || (end_addr > chk_cnt);
  assign over_limit = is_coil ? (req_r.quantity > 16'(MAX_COILS_PER_READ))
                              : (req_r.quantity > 16'(MAX_REGS_PER_READ));
  assign coil_bytes_w = 10'(req_r.quantity[8:0]) + 10'd7;

  // Header byte selection.
  logic [7:0] hdr_byte;
  always_comb begin
    case (idx_r)
      4'd0:    hdr_byte = req_r.transaction_id[15:8];
      4'd1:    hdr_byte = req_r.transaction_id[7:0];
      4'd2:    hdr_byte = req_r.protocol_id[15:8];
      4'd3:    hdr_byte = req_r.protocol_id[7:0];
      4'd4:    hdr_byte = 8'd0;
      4'd5:    hdr_byte = len_r;
      4'd6:    hdr_byte = unit_id_r;
      4'd7:    hdr_byte = req_r.function_code;
      4'd8:    hdr_byte = b8_r;
      4'd9:    hdr_byte = req_r.start_address[7:0];
      4'd10:   hdr_byte = req_r.coil_on ? mbtrr_pkg::COIL_ON_BYTE : 8'd0;
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    clr_nxt     = clr_r;
    idx_nxt     = idx_r;
    hdr_end_nxt = hdr_end_r;
    len_nxt     = len_r;
    b8_nxt      = b8_r;
    i_nxt       = i_r;
    bit_nxt     = bit_r;
    acc_nxt     = acc_r;
    emit        = 1'b0;
    emit_data   = '{resp_byte: 8'd0, resp_last: 1'b0, resp_status: mbtrr_pkg::ST_OK};
    coil_we = 1'b0; coil_wa = '0; coil_wd = 1'b0; coil_re = 1'b0;
    in_we   = 1'b0; in_wa   = '0; in_wd   = 16'd0; in_re = 1'b0;
    hold_we = 1'b0; hold_wa = '0; hold_wd = 16'd0; hold_re = 1'b0;

    unique case (state_r)
      mbtrr_pkg::S_CLEAR: begin
        coil_we = (17'(clr_r) < CDEP);
        coil_wa = clr_r[CAW-1:0];
        in_we   = (17'(clr_r) < IDEP);
        in_wa   = clr_r[IAW-1:0];
        hold_we = (17'(clr_r) < HDEP);
        hold_wa = clr_r[HAW-1:0];
        if (clr_r == CLW'(MAXD - 1)) begin
          state_nxt = mbtrr_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      mbtrr_pkg::S_IDLE: begin
        in_wa   = in_s.data.start_address[IAW-1:0];
        in_wd   = in_s.data.write_value;
        hold_wa = in_s.data.start_address[HAW-1:0];
        hold_wd = in_s.data.write_value;
        if (in_acc) begin
          in_we   = (in_s.data.req_type == mbtrr_pkg::REQ_IN_WRITE) &&
                    (17'(in_s.data.start_address) < nin);
          hold_we = (in_s.data.req_type == mbtrr_pkg::REQ_HR_WRITE) &&
                    (17'(in_s.data.start_address) < nhold);
          if (in_s.data.req_type == mbtrr_pkg::REQ_CLIENT) begin
            state_nxt = mbtrr_pkg::S_CHECK;
          end
        end
      end
      mbtrr_pkg::S_CHECK: begin
        idx_nxt = 4'd0;
        i_nxt   = 9'd0;
        bit_nxt = 3'd0;
        acc_nxt = 8'd0;
        state_nxt = mbtrr_pkg::S_ERR;
        if (!(is_coil || is_reg || is_wcoil)) begin
          status_nxt = mbtrr_pkg::ST_UNSUP;
        end else if (is_wcoil) begin
          if (17'(req_r.start_address) >= ncoil) begin
            status_nxt = mbtrr_pkg::ST_RANGE;
          end else begin
            coil_we     = 1'b1;
            coil_wa     = req_r.start_address[CAW-1:0];
            coil_wd     = req_r.coil_on;
            hdr_end_nxt = mbtrr_pkg::HDR_LAST_WCOIL;
            len_nxt     = mbtrr_pkg::WCOIL_LEN;
            b8_nxt      = req_r.start_address[15:8];
            state_nxt   = mbtrr_pkg::S_HDR;
          end
        end else if (chk_range) begin
          status_nxt = mbtrr_pkg::ST_RANGE;
        end else if (req_r.quantity == 16'd0) begin
          status_nxt = mbtrr_pkg::ST_EMPTY;
        end else if (over_limit) begin
          status_nxt = mbtrr_pkg::ST_LIMIT;
        end else begin
          hdr_end_nxt = mbtrr_pkg::HDR_LAST_READ;
          b8_nxt      = is_coil ? 8'(coil_bytes_w[9:3]) : {2'b00, req_r.quantity[4:0], 1'b0};
          len_nxt     = 8'(mbtrr_pkg::HDR_BYTES) + b8_nxt - 8'd6;
          state_nxt   = mbtrr_pkg::S_HDR;
        end
      end
      mbtrr_pkg::S_ERR: begin
        if (o_free) begin
          emit      = 1'b1;
          emit_data = '{resp_byte: 8'd0, resp_last: 1'b1, resp_status: status_r};
          state_nxt = mbtrr_pkg::S_IDLE;
        end
      end
      mbtrr_pkg::S_HDR: begin
        if (o_free) begin
          emit      = 1'b1;
          emit_data.resp_byte = hdr_byte;
          emit_data.resp_last = is_wcoil && (idx_r == hdr_end_r);
          if (idx_r == hdr_end_r) begin
            state_nxt = is_wcoil ? mbtrr_pkg::S_IDLE :
                        is_coil  ? mbtrr_pkg::S_CREQ : mbtrr_pkg::S_RREQ;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      mbtrr_pkg::S_RREQ: begin
        hold_re   = (req_r.function_code == mbtrr_pkg::FC_READ_HOLD);
        in_re     = !hold_re;
        state_nxt = mbtrr_pkg::S_RHI;
      end
      mbtrr_pkg::S_RHI: begin
        if (o_free) begin
          emit      = 1'b1;
          emit_data.resp_byte = reg_rd[15:8];
          state_nxt = mbtrr_pkg::S_RLO;
        end
      end
      mbtrr_pkg::S_RLO: begin
        if (o_free) begin
          emit      = 1'b1;
          emit_data.resp_byte = reg_rd[7:0];
          emit_data.resp_last = ((i_r + 9'd1) == req_r.quantity[8:0]);
          i_nxt     = i_r + 9'd1;
          state_nxt = emit_data.resp_last ? mbtrr_pkg::S_IDLE : mbtrr_pkg::S_RREQ;
        end
      end
      mbtrr_pkg::S_CREQ: begin
        coil_re   = 1'b1;
        state_nxt = mbtrr_pkg::S_CACC;
      end
      mbtrr_pkg::S_CACC: begin
        acc_nxt[bit_r] = coil_rd;
        i_nxt = i_r + 9'd1;
        if (bit_r == 3'd7 || (i_r + 9'd1) == req_r.quantity[8:0]) begin
          state_nxt = mbtrr_pkg::S_CEMIT;
        end else begin
          bit_nxt   = bit_r + 3'd1;
          state_nxt = mbtrr_pkg::S_CREQ;
        end
      end
      mbtrr_pkg::S_CEMIT: begin
        if (o_free) begin
          emit      = 1'b1;
          emit_data.resp_byte = acc_r;
          emit_data.resp_last = (i_r == req_r.quantity[8:0]);
          acc_nxt   = 8'd0;
          bit_nxt   = 3'd0;
          state_nxt = emit_data.resp_last ? mbtrr_pkg::S_IDLE : mbtrr_pkg::S_CREQ;
        end
      end
      default: state_nxt = mbtrr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mbtrr_pkg::S_CLEAR;
      clr_r     <= '0;
      o_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (emit) begin
        o_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Payload and datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_s.data;
    end
    if (emit) begin
      o_data_r <= emit_data;
    end
    status_r  <= status_nxt;
    idx_r     <= idx_nxt;
    hdr_end_r <= hdr_end_nxt;
    len_r     <= len_nxt;
    b8_r      <= b8_nxt;
    i_r       <= i_nxt;
    bit_r     <= bit_nxt;
    acc_r     <= acc_nxt;
  end

  // An error beat is always a single zero byte marked last.
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && (o_data_r.resp_status != mbtrr_pkg::ST_OK) |->
      o_data_r.resp_last && (o_data_r.resp_byte == 8'd0))
    else $error("error beat not a lone zero byte");

  // A new beat is never produced while the held beat is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && !out_s.ready |-> !emit)
    else $error("output beat overwritten under stall");

  // The header counter never runs past the last header byte.
  a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbtrr_pkg::S_HDR) |-> (idx_r <= hdr_end_r))
    else $error("header index out of range");

  // Coil packing hands over a byte after at most eight coils.
  a_coil_pack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbtrr_pkg::S_CACC) && (bit_r == 3'd7) |=>
      (state_r == mbtrr_pkg::S_CEMIT))
    else $error("coil byte not emitted after eight coils");
endmodule

// ----- rtl/mbtrr_ram.sv -----
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data. Stand-alone, no package dependency.
module mbtrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sim/stream_if_sim.sv -----
// Constants shared by the responder testbench.
// Depends on nothing; the stream interface itself lives in rtl/mbtrr_stream_if.sv.
package mbtrr_sim_pkg;
  localparam int RESP_BYTES_MAX = 64;
endpackage

// ----- sim/testbench.sv -----
// Self-checking testbench for the Modbus TCP register responder.
// Depends on mbtrr_pkg, mbtrr_sim_pkg, mbtrr_stream_if and the responder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [10:0] cfg_wdata = '0;

  mbtrr_stream_if #(.T(mbtrr_pkg::req_t)) req_ch();
  mbtrr_stream_if #(.T(mbtrr_pkg::resp_t)) resp_ch();

  modbus_tcp_register_responder u_top (
    .clk(clk), .rst_n(rst_n), .in_s(req_ch.sink), .out_s(resp_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the block: configuration and the three stores.
  logic [7:0]  unit_id_m;
  logic [10:0] coil_cnt_m;
  logic [8:0]  in_cnt_m, hold_cnt_m;
  logic        coil_m [1024];
  logic [15:0] in_m [256];
  logic [15:0] hold_m [256];

  mbtrr_pkg::resp_t frame_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    idle_on = 1'b1;
  bit    hold_req = 1'b0;
  bit    hold_done = 1'b0;
  int    hold_left = 0;
  int    burst_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void push_error(input mbtrr_pkg::status_t st);
    mbtrr_pkg::resp_t r;
    r.resp_byte = 8'h00;
    r.resp_last = 1'b1;
    r.resp_status = st;
    frame_q.push_back(r);
  endfunction

  // Predicts every beat of the response frame and applies the store updates.
  function automatic void predict_frame(input mbtrr_pkg::req_t q);
    logic [7:0] buf_b [mbtrr_sim_pkg::RESP_BYTES_MAX];
    int n, ncoil, cnt, len;
    logic [31:0] s, qty;
    mbtrr_pkg::resp_t r;
    ncoil = (coil_cnt_m > 11'd1024) ? 1024 : int'(coil_cnt_m);
    s = 32'(q.start_address);
    qty = 32'(q.quantity);
    if (q.req_type == mbtrr_pkg::REQ_IN_WRITE) begin
      if (s < ((in_cnt_m > 9'd256) ? 256 : int'(in_cnt_m))) in_m[s] = q.write_value;
      return;
    end
    if (q.req_type == mbtrr_pkg::REQ_HR_WRITE) begin
      if (s < ((hold_cnt_m > 9'd256) ? 256 : int'(hold_cnt_m))) hold_m[s] = q.write_value;
      return;
    end
    if (q.req_type != mbtrr_pkg::REQ_CLIENT) return;
    for (int i = 0; i < mbtrr_sim_pkg::RESP_BYTES_MAX; i++) buf_b[i] = 8'h00;
    case (q.function_code) inside
      mbtrr_pkg::FC_READ_COILS: begin
        if (s >= ncoil || s + qty > ncoil) begin
          push_error(mbtrr_pkg::ST_RANGE); return;
        end
        if (qty == 0) begin push_error(mbtrr_pkg::ST_EMPTY); return; end
        if (qty > 440) begin push_error(mbtrr_pkg::ST_LIMIT); return; end
        for (int i = 0; i < qty; i++)
          if (coil_m[s + i]) buf_b[9 + i / 8][i % 8] = 1'b1;
        n = 9 + int'((qty + 7) / 8);
        buf_b[8] = 8'((qty + 7) / 8);
      end
      mbtrr_pkg::FC_READ_HOLD, mbtrr_pkg::FC_READ_INPUT: begin
        cnt = (q.function_code == mbtrr_pkg::FC_READ_HOLD) ? int'(hold_cnt_m)
                                                            : int'(in_cnt_m);
        if (cnt > 256) cnt = 256;
        if (s >= cnt || s + qty > cnt) begin push_error(mbtrr_pkg::ST_RANGE); return; end
        if (qty == 0) begin push_error(mbtrr_pkg::ST_EMPTY); return; end
        if (qty > 27) begin push_error(mbtrr_pkg::ST_LIMIT); return; end
        for (int i = 0; i < qty; i++) begin
          {buf_b[9 + 2 * i], buf_b[10 + 2 * i]} =
            (q.function_code == mbtrr_pkg::FC_READ_HOLD) ? hold_m[s + i] : in_m[s + i];
        end
        n = 9 + 2 * int'(qty);
        buf_b[8] = 8'(2 * qty);
      end
      mbtrr_pkg::FC_WRITE_COIL: begin
        if (s >= ncoil) begin push_error(mbtrr_pkg::ST_RANGE); return; end
        coil_m[s] = q.coil_on;
        {buf_b[8], buf_b[9]} = q.start_address;
        buf_b[10] = q.coil_on ? mbtrr_pkg::COIL_ON_BYTE : 8'h00;
        n = 11;
      end
      default: begin push_error(mbtrr_pkg::ST_UNSUP); return; end
    endcase
    // The write coil frame reports a length of 6 although it carries 11 bytes.
    len = (q.function_code == mbtrr_pkg::FC_WRITE_COIL) ? int'(mbtrr_pkg::WCOIL_LEN) : n - 6;
    {buf_b[0], buf_b[1]} = q.transaction_id;
    {buf_b[2], buf_b[3]} = q.protocol_id;
    {buf_b[4], buf_b[5]} = len[15:0];
    buf_b[6] = unit_id_m;
    buf_b[7] = q.function_code;
    for (int i = 0; i < n; i++) begin
      r.resp_byte = buf_b[i];
      r.resp_last = (i == n - 1);
      r.resp_status = mbtrr_pkg::ST_OK;
      frame_q.push_back(r);
    end
  endfunction

  // Response checker: every accepted beat against the oldest prediction.
  always @(posedge clk) begin
    mbtrr_pkg::resp_t got, want;
    cycles <= cycles + 1;
    if (rst_n && resp_ch.valid && resp_ch.ready) begin
      got = resp_ch.data;
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected beat", int'(got), 0);
      end else begin
        want = frame_q.pop_front();
        if (got.resp_byte !== want.resp_byte)
          report_mismatch("resp_byte", int'(got.resp_byte), int'(want.resp_byte));
        if (got.resp_last !== want.resp_last)
          report_mismatch("resp_last", int'(got.resp_last), int'(want.resp_last));
        if (got.resp_status !== want.resp_status)
          report_mismatch("resp_status", int'(got.resp_status), int'(want.resp_status));
      end
    end
  end

  // Long receiver hold-off, counted here once it is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Receiver: random stall bursts and the long hold-off.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      resp_ch.ready <= 1'b0;
    end else if (burst_left != 0) begin
      resp_ch.ready <= 1'b0;
      burst_left <= burst_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      resp_ch.ready <= 1'b0;
      burst_left <= $urandom_range(0, 18);
    end else begin
      resp_ch.ready <= 1'b1;
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    if (cycles > 5000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sends one beat, with an optional random gap first; the prediction is made
  // on the edge where the beat is accepted. Valid stays up until the next gap
  // or drain.
  task automatic send_req(input mbtrr_pkg::req_t q);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    do @(posedge clk); while (!req_ch.ready);
    predict_frame(q);
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mbtrr_pkg::CFG_UNIT_ID:   unit_id_m = val[7:0];
      mbtrr_pkg::CFG_COIL_CNT:  coil_cnt_m = val[10:0];
      mbtrr_pkg::CFG_INPUT_CNT: in_cnt_m = val[8:0];
      mbtrr_pkg::CFG_HOLD_CNT:  hold_cnt_m = val[8:0];
      default: ;
    endcase
  endtask

  function automatic mbtrr_pkg::req_t client(input logic [7:0] fc, input int s,
                                              input int qty);
    mbtrr_pkg::req_t q;
    q.req_type = mbtrr_pkg::REQ_CLIENT;
    q.transaction_id = 16'($urandom);
    q.protocol_id = 16'($urandom);
    q.function_code = fc;
    q.start_address = 16'(s);
    q.quantity = 16'(qty);
    q.coil_on = 1'($urandom);
    q.write_value = 16'($urandom);
    return q;
  endfunction

  function automatic mbtrr_pkg::req_t local_wr(input logic [1:0] kind, input int s);
    mbtrr_pkg::req_t q;
    q = client(mbtrr_pkg::FC_READ_HOLD, s, $urandom);
    q.req_type = kind;
    return q;
  endfunction

  // Directed: each function, each error status and the field extremes.
  task automatic test_directed();
    mbtrr_pkg::req_t q;
    send_req(local_wr(mbtrr_pkg::REQ_IN_WRITE, 0));
    send_req(local_wr(mbtrr_pkg::REQ_HR_WRITE, 255));
    send_req(local_wr(mbtrr_pkg::REQ_HR_WRITE, 256));
    send_req(local_wr(2'd3, 5));
    q = client(mbtrr_pkg::FC_WRITE_COIL, 0, 0); q.coil_on = 1'b1; send_req(q);
    q = client(mbtrr_pkg::FC_WRITE_COIL, 1023, 65535); q.coil_on = 1'b1; send_req(q);
    send_req(client(mbtrr_pkg::FC_WRITE_COIL, 1024, 1));
    send_req(client(mbtrr_pkg::FC_READ_COILS, 0, 440));
    send_req(client(mbtrr_pkg::FC_READ_COILS, 584, 440));
    send_req(client(mbtrr_pkg::FC_READ_COILS, 0, 441));
    send_req(client(mbtrr_pkg::FC_READ_COILS, 5, 0));
    send_req(client(mbtrr_pkg::FC_READ_COILS, 65535, 65535));
    send_req(client(mbtrr_pkg::FC_READ_HOLD, 229, 27));
    send_req(client(mbtrr_pkg::FC_READ_HOLD, 0, 28));
    send_req(client(mbtrr_pkg::FC_READ_INPUT, 0, 1));
    send_req(client(mbtrr_pkg::FC_READ_INPUT, 255, 2));
    send_req(client(mbtrr_pkg::FC_READ_INPUT, 3, 0));
    send_req(client(8'd0, 0, 1));
    send_req(client(8'd255, 0, 1));
    send_req(client(8'd2, 0, 1));
    q = client(mbtrr_pkg::FC_READ_HOLD, 0, 1);
    q.transaction_id = 16'hFFFF; q.protocol_id = 16'h0000;
    send_req(q);
    wait_drain();
  endtask

  // Random stimulus: mostly well-formed requests and store writes.
  task automatic test_random(input int count);
    int pick, s, qty;
    logic [7:0] fc;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_req(local_wr(2'($urandom_range(1, 2)), $urandom_range(0, 300)));
      end else if (pick < 35) begin
        send_req(client(8'($urandom), $urandom, $urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: fc = mbtrr_pkg::FC_READ_COILS;
          1: fc = mbtrr_pkg::FC_READ_HOLD;
          2: fc = mbtrr_pkg::FC_READ_INPUT;
          default: fc = mbtrr_pkg::FC_WRITE_COIL;
        endcase
        if (fc == mbtrr_pkg::FC_READ_COILS) begin
          s = $urandom_range(0, 1030);
          qty = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 500) : $urandom_range(0, 40);
        end else begin
          s = $urandom_range(0, (fc == mbtrr_pkg::FC_WRITE_COIL) ? 1030 : 260);
          qty = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 28);
        end
        send_req(client(fc, s, qty));
      end
    end
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    @(posedge clk);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_req(client(mbtrr_pkg::FC_READ_HOLD, 0, 27));
    hold_req = 1'b0;
    wait_drain();
  endtask

  task automatic test_config_sweep();
    write_cfg(mbtrr_pkg::CFG_UNIT_ID, 255);
    write_cfg(mbtrr_pkg::CFG_COIL_CNT, 16);
    write_cfg(mbtrr_pkg::CFG_INPUT_CNT, 8);
    write_cfg(mbtrr_pkg::CFG_HOLD_CNT, 0);
    test_random(60);
    wait_drain();
    write_cfg(mbtrr_pkg::CFG_UNIT_ID, 0);
    write_cfg(mbtrr_pkg::CFG_COIL_CNT, 2047);
    write_cfg(mbtrr_pkg::CFG_INPUT_CNT, 511);
    write_cfg(mbtrr_pkg::CFG_HOLD_CNT, 100);
    test_random(60);
    wait_drain();
    write_cfg(mbtrr_pkg::CFG_COIL_CNT, 0);
    write_cfg(mbtrr_pkg::CFG_INPUT_CNT, 256);
    write_cfg(mbtrr_pkg::CFG_HOLD_CNT, 256);
    test_random(30);
    wait_drain();
    write_cfg(mbtrr_pkg::CFG_UNIT_ID, 8'h5A);
    write_cfg(mbtrr_pkg::CFG_COIL_CNT, 1024);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    unit_id_m = 8'd1;
    coil_cnt_m = 11'd1024;
    in_cnt_m = 9'd256;
    hold_cnt_m = 9'd256;
    for (int i = 0; i < 1024; i++) coil_m[i] = 1'b0;
    for (int i = 0; i < 256; i++) begin in_m[i] = '0; hold_m[i] = '0; end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(150);
    wait_drain();
    test_config_sweep();
    // Final stretch runs with no idling on either side.
    idle_on = 1'b0;
    test_random(90);
    wait_drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/mbtrr_pkg.sv
rtl/mbtrr_stream_if.sv
rtl/mbtrr_ram.sv
rtl/modbus_tcp_register_responder.sv
sim/stream_if_sim.sv
sim/testbench.sv
